FILE: hw/rtl/stp_pkg.sv
`default_nettype none

package stp_pkg;

    localparam int CAND_W       = 20;
    localparam int CFG_W        = 11;
    localparam int CFG_RESET    = 1024;
    localparam int SMALL_PRIME  = 2;
    localparam int DEF_MAX_BASE = 1024;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;

    // memory read address source
    typedef enum logic {
        RSEL_P,
        RSEL_CAND
    } t_rsel;

    // memory write address source
    typedef enum logic {
        WSEL_INIT,
        WSEL_MARK
    } t_wsel;

    typedef struct packed {
        logic  mem_we;
        logic  mem_wdata;
        t_wsel wsel;
        t_rsel rsel;
        logic  load_cand;
        logic  p_set2;
        logic  p_inc;
        logic  m_zero;
        logic  m_inc;
        logic  m_set2p;
        logic  m_addp;
        logic  div_start;
        logic  div_step;
        logic  out_load;
        logic  out_prime;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic cand_lt2;
        logic cand_le_lim;
        logic init_last;
        logic p2_gt_lim;
        logic p_gt_lim;
        logic m_gt_lim;
        logic rd_bit;
        logic div_last;
        logic rem_zero;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/stp_datapath.sv
`default_nettype none

module stp_datapath import stp_pkg::*; #(
    parameter int MAX_BASE = DEF_MAX_BASE
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic [CAND_W-1:0]      i_cand,
    input  wire t_cmd                   i_cmd,
    output t_sts                        o_sts,
    output logic [OUT_TDATA_W-1:0]      o_tdata
);

    localparam int LIM_W = $clog2(MAX_BASE + 1);
    localparam int PW    = LIM_W + 1;
    localparam int DEPTH = MAX_BASE - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = 2 * PW;
    localparam int CMP_W = (BW > CAND_W) ? BW : CAND_W;
    localparam int BIT_W = $clog2(CAND_W);

    logic [CFG_W-1:0]  r_base_limit;
    logic [LIM_W-1:0]  lim;
    logic [BW-1:0]     r_bound;
    logic [CAND_W-1:0] r_cand;
    logic [PW-1:0]     r_p;
    logic [PW-1:0]     r_m;
    logic [LIM_W-1:0]  r_rem;
    logic [BIT_W-1:0]  r_bit;
    logic              r_rd;
    logic              r_out_prime;
    logic              r_out_range;
    logic              mem [DEPTH];
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [PW-1:0]     p_m2;
    logic [PW-1:0]     m_m2;
    logic [CAND_W-1:0] cand_m2;
    logic [LIM_W:0]    rem_sh;
    logic [LIM_W-1:0]  n_rem;
    logic [PW-1:0]     lim_p;
    logic [PW-1:0]     lim_p1;

    // limit saturated to 2..MAX_BASE
    always_comb begin
        if (int'(r_base_limit) < SMALL_PRIME) begin
            lim = LIM_W'(SMALL_PRIME);
        end else if (int'(r_base_limit) > MAX_BASE) begin
            lim = LIM_W'(MAX_BASE);
        end else begin
            lim = LIM_W'(r_base_limit);
        end
    end

    assign lim_p   = PW'(lim);
    assign lim_p1  = lim_p + PW'(1);
    assign p_m2    = r_p - PW'(SMALL_PRIME);
    assign m_m2    = r_m - PW'(SMALL_PRIME);
    assign cand_m2 = r_cand - CAND_W'(SMALL_PRIME);

    assign raddr = (i_cmd.rsel == RSEL_CAND) ? cand_m2[AW-1:0] : p_m2[AW-1:0];
    assign waddr = (i_cmd.wsel == WSEL_MARK) ? m_m2[AW-1:0] : r_m[AW-1:0];

    // one restoring step of cand % p
    assign rem_sh = {r_rem, r_cand[r_bit]};
    assign n_rem  = (rem_sh >= {1'b0, r_p[LIM_W-1:0]})
                  ? LIM_W'(rem_sh - {1'b0, r_p[LIM_W-1:0]}) : rem_sh[LIM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_limit <= CFG_W'(CFG_RESET);
        end else if (i_cfg_we) begin
            r_base_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[waddr] <= i_cmd.mem_wdata;
        end
        r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        r_bound <= lim_p1 * lim_p1;
        if (i_cmd.load_cand) begin
            r_cand <= i_cand;
        end
        if (i_cmd.p_set2) begin
            r_p <= PW'(SMALL_PRIME);
        end else if (i_cmd.p_inc) begin
            r_p <= r_p + PW'(1);
        end
        if (i_cmd.m_zero) begin
            r_m <= '0;
        end else if (i_cmd.m_inc) begin
            r_m <= r_m + PW'(1);
        end else if (i_cmd.m_set2p) begin
            r_m <= r_p + r_p;
        end else if (i_cmd.m_addp) begin
            r_m <= r_m + r_p;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_bit <= BIT_W'(CAND_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_bit <= r_bit - BIT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_prime <= i_cmd.out_prime;
            r_out_range <= CMP_W'(r_cand) >= CMP_W'(r_bound);
        end
    end

    always_comb begin
        o_sts.cfg_wr      = i_cfg_we;
        o_sts.cand_lt2    = r_cand < CAND_W'(SMALL_PRIME);
        o_sts.cand_le_lim = r_cand <= CAND_W'(lim);
        o_sts.init_last   = r_m == lim_p - PW'(SMALL_PRIME);
        o_sts.p2_gt_lim   = (r_p + r_p) > lim_p;
        o_sts.p_gt_lim    = r_p > lim_p;
        o_sts.m_gt_lim    = r_m > lim_p;
        o_sts.rd_bit      = r_rd;
        o_sts.div_last    = r_bit == '0;
        o_sts.rem_zero    = r_rem == '0;
    end

    assign o_tdata = {{(OUT_TDATA_W - 2){1'b0}}, r_out_range, r_out_prime};

endmodule

`default_nettype wire

FILE: hw/rtl/stp_ctrl.sv
`default_nettype none

module stp_ctrl import stp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_CLR,
        S_SV_RD,
        S_SV_CHK,
        S_SV_MARK,
        S_CLASSIFY,
        S_LOOKUP,
        S_TD_RD,
        S_TD_CHK,
        S_TD_DIV,
        S_TD_TEST,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_map_ready;
    logic   n_map_ready;
    logic   r_prime;
    logic   n_prime;
    logic   r_out_valid;
    logic   building;

    assign building    = (r_state == S_INIT_CLR) || (r_state == S_SV_RD)
                      || (r_state == S_SV_CHK) || (r_state == S_SV_MARK);
    assign o_in_ready  = (r_state == S_IDLE) && r_map_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.wsel  = WSEL_INIT;
        o_cmd.rsel  = RSEL_P;
        n_state     = r_state;
        n_map_ready = r_map_ready && !i_sts.cfg_wr;
        n_prime     = r_prime;
        unique case (r_state)
            S_IDLE: begin
                if (!r_map_ready) begin
                    o_cmd.m_zero = 1'b1;
                    n_state      = S_INIT_CLR;
                end else if (i_in_valid) begin
                    o_cmd.load_cand = 1'b1;
                    n_state         = S_CLASSIFY;
                end
            end
            S_INIT_CLR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.mem_wdata = 1'b1;
                o_cmd.m_inc     = 1'b1;
                if (i_sts.init_last) begin
                    o_cmd.p_set2 = 1'b1;
                    n_state      = S_SV_RD;
                end
            end
            S_SV_RD: begin
                if (i_sts.p2_gt_lim) begin
                    n_map_ready = !i_sts.cfg_wr;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_SV_CHK;
                end
            end
            S_SV_CHK: begin
                if (i_sts.rd_bit) begin
                    o_cmd.m_set2p = 1'b1;
                    n_state       = S_SV_MARK;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = S_SV_RD;
                end
            end
            S_SV_MARK: begin
                if (i_sts.m_gt_lim) begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = S_SV_RD;
                end else begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wsel   = WSEL_MARK;
                    o_cmd.m_addp = 1'b1;
                end
            end
            S_CLASSIFY: begin
                o_cmd.rsel   = RSEL_CAND;
                o_cmd.p_set2 = 1'b1;
                if (i_sts.cand_lt2) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else if (i_sts.cand_le_lim) begin
                    n_state = S_LOOKUP;
                end else begin
                    n_state = S_TD_RD;
                end
            end
            S_LOOKUP: begin
                n_prime = i_sts.rd_bit;
                n_state = S_DONE;
            end
            S_TD_RD: begin
                if (i_sts.p_gt_lim) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TD_CHK;
                end
            end
            S_TD_CHK: begin
                if (i_sts.rd_bit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_TD_DIV;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = S_TD_RD;
                end
            end
            S_TD_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_TD_TEST;
                end
            end
            S_TD_TEST: begin
                if (i_sts.rem_zero) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = S_TD_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_prime = r_prime;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a limit change while building restarts the sieve
        if (building && i_sts.cfg_wr) begin
            o_cmd.mem_we = 1'b0;
            o_cmd.m_zero = 1'b1;
            n_map_ready  = 1'b0;
            n_state      = S_INIT_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_ready <= 1'b0;
            r_out_valid <= 1'b0;
            r_prime     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map_ready <= n_map_ready;
            r_prime     <= n_prime;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sieve_trial_division_prime_test.sv
// prime test of one candidate per beat against a sieve of base primes
//
// input stream: tdata[19:0] carries the candidate; a beat moves when tvalid and
// tready are both high. output stream: one result beat per input beat,
// tdata[0] = is_prime, tdata[1] = out_of_range (candidate >= (limit+1)^2).
// config channel: one beat writes base_limit (11 bits); the limit in use is
// base_limit saturated to 2..MAX_BASE. write it only while no item is in flight.
//
// after reset (limit 1024) and after every limit write the block rebuilds the
// base-prime bitmap in a ram with one write and one read port before taking
// the next candidate: it presets the map, then reads each base number up to
// limit/2 and, for each one still marked, clears its multiples in the map.
// per candidate: below 2 is rejected at once, up to the limit it is one ram
// read. above the limit each number 2..limit is scanned in the map and each
// base prime is tried on the bit-serial remainder unit, so a prime candidate
// costs a full scan and a division by every base prime;
// a composite stops at its smallest factor.
// the result sits in an output register, so a stalled receiver does not stop
// the next candidate from being taken; only a second finished result waits.
`default_nettype none

module sieve_trial_division_prime_test import stp_pkg::*; #(
    parameter int MAX_BASE = DEF_MAX_BASE
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_W-1:0]       i_cfg_data,       // base_limit
    // candidate stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [19:0] candidate
    // result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata    // [0] is_prime, [1] out_of_range
);

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    // the limit register takes a write in any cycle
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    stp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    stp_datapath #(
        .MAX_BASE (MAX_BASE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cand     (i_s_axis_tdata[CAND_W-1:0]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_tdata    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: dv/tb_sieve_trial_division_prime_test.sv
`default_nettype none

module tb_sieve_trial_division_prime_test import stp_pkg::*; ;

    localparam int MAX_BASE  = DEF_MAX_BASE;
    localparam int N_DIRECT  = 30;
    localparam int N_PHASES  = 10;
    localparam int PER_PHASE = 30;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_LIMIT,       // write base_limit, value[10:0]
        ROW_CAND,        // candidate, verdict from the predictor
        ROW_CAND_KNOWN   // candidate, verdict typed in the row
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CAND_W-1:0] value;
        logic              prime;
        logic              oor;
    } t_stim_row;

    // one expected result beat, candidate kept for messages
    typedef struct packed {
        logic [CAND_W-1:0] cand;
        logic              prime;
        logic              oor;
    } t_prime_verdict;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [19:0] candidate
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [0] is_prime, [1] out_of_range

    // predictor state: the programmed limit and the base-prime map built from it
    logic [CFG_W-1:0] limit_reg   = CFG_W'(CFG_RESET);
    bit               sieve_valid = 1'b0;
    bit               base_prime [0:MAX_BASE];

    t_prime_verdict verdicts_due [$];
    int             errors     = 0;
    int             burst_left = 0;

    sieve_trial_division_prime_test #(
        .MAX_BASE(MAX_BASE)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // hard stop, well beyond a run where every candidate is a prime at the top limit
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // limit in use: the register saturated to 2..MAX_BASE
    function automatic int unsigned limit_in_use();
        int unsigned lim;
        lim = int'(limit_reg);
        if (lim < SMALL_PRIME) lim = SMALL_PRIME;
        if (lim > MAX_BASE) lim = MAX_BASE;
        return lim;
    endfunction

    function automatic t_prime_verdict predict_verdict(input logic [CAND_W-1:0] cand);
        int unsigned    lim;
        int unsigned    p;
        int unsigned    m;
        t_prime_verdict v;
        lim = limit_in_use();
        // lazy rebuild of the sieve, as the block does before its next test
        if (!sieve_valid) begin
            for (p = 0; p <= MAX_BASE; p++) base_prime[p] = (p >= SMALL_PRIME && p <= lim);
            for (p = SMALL_PRIME; p <= lim; p++) begin
                if (base_prime[p]) begin
                    for (m = p + p; m <= lim; m += p) base_prime[m] = 1'b0;
                end
            end
            sieve_valid = 1'b1;
        end
        v.cand = cand;
        v.oor  = (cand >= (lim + 1) * (lim + 1));
        if (cand < SMALL_PRIME) begin
            v.prime = 1'b0;
        end else if (cand <= lim) begin
            v.prime = base_prime[cand];
        end else begin
            // trial division by every base prime, stop at the first factor
            v.prime = 1'b1;
            for (p = SMALL_PRIME; p <= lim; p++) begin
                if (base_prime[p] && (cand % p) == 0) begin
                    v.prime = 1'b0;
                    break;
                end
            end
        end
        return v;
    endfunction

    // drive one candidate beat; the sender runs in bursts with random gaps
    task automatic offer_candidate(input logic [CAND_W-1:0] cand, input bit known,
                                   input logic prime, input logic oor);
        t_prime_verdict v;
        int             gap;
        s_tdata  <= {{(IN_TDATA_W-CAND_W){1'b0}}, cand};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (known) begin
            v.cand  = cand;
            v.prime = prime;
            v.oor   = oor;
        end else begin
            v = predict_verdict(cand);
        end
        verdicts_due.push_back(v);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // only drop valid when a real gap follows, so it never toggles within one step
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 7) == 0) burst_left = 50;
        end
    endtask

    // limit writes only while idle: every result of earlier candidates taken
    task automatic program_limit(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        limit_reg   = value;
        sieve_valid = 1'b0;
    endtask

    // result side: check each beat against the oldest pending verdict,
    // stall on a pattern that changes mode every so often
    int stall_mode = 0;
    int mode_left  = 0;
    always @(posedge clk) begin : result_check
        t_prime_verdict want;
        if (rst_n && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("result beat with no candidate pending, tdata=%h", m_tdata);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_tdata[0] !== want.prime) begin
                    $error("is_prime for candidate %0d: expected %0b, got %0b",
                           want.cand, want.prime, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.oor) begin
                    $error("out_of_range for candidate %0d: expected %0b, got %0b",
                           want.cand, want.oor, m_tdata[1]);
                    errors++;
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;                          // no back-pressure
            1: m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
            2: m_tready <= ($urandom_range(0, 3) != 0);   // light stalls
            default: m_tready <= ~m_tready;               // alternating stalls
        endcase
    end

    // directed part: extremes of candidate and limit, saturation both ways,
    // candidates below two, the out-of-range boundary, a slow prime at the top limit
    t_stim_row directed_rows [0:N_DIRECT-1] = '{
        '{ROW_CAND_KNOWN, 20'd0,       1'b0, 1'b0},   // below two, reset limit 1024
        '{ROW_CAND_KNOWN, 20'd1,       1'b0, 1'b0},
        '{ROW_CAND_KNOWN, 20'd2,       1'b1, 1'b0},   // smallest prime, from the map
        '{ROW_CAND_KNOWN, 20'd1024,    1'b0, 1'b0},   // even, right at the limit
        '{ROW_CAND,       20'd1021,    1'b0, 1'b0},
        '{ROW_CAND,       20'd1025,    1'b0, 1'b0},   // first trial-divided number
        '{ROW_CAND,       20'd1048573, 1'b0, 1'b0},   // largest 20-bit prime, full scan
        '{ROW_CAND,       20'hFFFFF,   1'b0, 1'b0},
        '{ROW_LIMIT,      20'd2047,    1'b0, 1'b0},   // saturates down to MAX_BASE
        '{ROW_CAND,       20'd1027,    1'b0, 1'b0},
        '{ROW_CAND,       20'd1023,    1'b0, 1'b0},
        '{ROW_LIMIT,      20'd0,       1'b0, 1'b0},   // saturates up to two
        '{ROW_CAND_KNOWN, 20'hFFFFF,   1'b1, 1'b1},   // odd, only 2 tried, far out of range
        '{ROW_CAND_KNOWN, 20'd1,       1'b0, 1'b0},
        '{ROW_CAND,       20'd9,       1'b0, 1'b0},   // exactly (2+1)^2
        '{ROW_CAND,       20'd8,       1'b0, 1'b0},
        '{ROW_CAND,       20'd3,       1'b0, 1'b0},
        '{ROW_LIMIT,      20'd1,       1'b0, 1'b0},
        '{ROW_CAND,       20'd2,       1'b0, 1'b0},
        '{ROW_CAND,       20'd5,       1'b0, 1'b0},
        '{ROW_LIMIT,      20'd3,       1'b0, 1'b0},
        '{ROW_CAND,       20'd15,      1'b0, 1'b0},
        '{ROW_CAND,       20'd16,      1'b0, 1'b0},
        '{ROW_LIMIT,      20'd1000,    1'b0, 1'b0},
        '{ROW_CAND,       20'd1002001, 1'b0, 1'b0},   // 1001^2, first out-of-range value
        '{ROW_CAND,       20'd1002000, 1'b0, 1'b0},
        '{ROW_CAND,       20'd999983,  1'b0, 1'b0},
        '{ROW_LIMIT,      20'd1024,    1'b0, 1'b0},
        '{ROW_CAND,       20'hFFFFF,   1'b0, 1'b0},
        '{ROW_CAND_KNOWN, 20'd0,       1'b0, 1'b0}
    };

    initial begin : stimulus
        int unsigned lim;
        int unsigned bound;
        int unsigned c;
        int unsigned a;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECT; r++) begin
            case (directed_rows[r].kind)
                ROW_LIMIT:      program_limit(directed_rows[r].value[CFG_W-1:0]);
                ROW_CAND:       offer_candidate(directed_rows[r].value, 1'b0, 1'b0, 1'b0);
                ROW_CAND_KNOWN: offer_candidate(directed_rows[r].value, 1'b1,
                                                directed_rows[r].prime, directed_rows[r].oor);
                default: ;
            endcase
        end

        // random phases: mostly small limits so scans stay short, now and then
        // any 11-bit value, saturation included
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph % 4 == 3) program_limit(CFG_W'($urandom_range(0, 2047)));
            else             program_limit(CFG_W'($urandom_range(2, 64)));
            lim   = limit_in_use();
            bound = (lim + 1) * (lim + 1);
            for (int n = 0; n < PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: c = $urandom_range(0, 20'hFFFFF);
                    4, 5:       c = $urandom_range(0, lim + 2);         // map lookups
                    6, 7:       c = bound - 2 + $urandom_range(0, 4);   // range edge
                    8: begin                                            // product of two
                        a = $urandom_range(2, lim);
                        c = a * $urandom_range(2, lim);
                    end
                    default: begin                                      // a square
                        a = $urandom_range(2, lim + 1);
                        c = a * a;
                    end
                endcase
                if (c > 20'hFFFFF) c = 20'hFFFFF;
                offer_candidate(c[CAND_W-1:0], 1'b0, 1'b0, 1'b0);
            end
        end

        // drain, then a quiet stretch to catch stray result beats
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
